### hdl/integral_image_builder_defines.svh
// Assertion macros used by the integral image builder RTL.
// Included by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef INTEGRAL_IMAGE_BUILDER_DEFINES_SVH
`define INTEGRAL_IMAGE_BUILDER_DEFINES_SVH

`ifndef SYNTH

// Antecedent in one cycle implies consequent in the next.
`define IIB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("integral image builder: check failed");

// Antecedent implies consequent in the same cycle.
`define IIB_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("integral image builder: check failed");

`else

`define IIB_ASSERT_NEXT(lbl, ante, cons)
`define IIB_ASSERT_SAME(lbl, ante, cons)

`endif

`endif

### hdl/iib_pkg.sv
// Shared types, widths and helpers for the integral image builder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package iib_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int DIM_W     = 11;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int PIX_W     = 8;
	localparam int ROW_SUM_W = 18;
	localparam int AREA_W    = 28;
	localparam int CFG_IDX_W = 1;
	localparam int S_TDATA_W = ((PIX_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((AREA_W + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = CFG_IDX_W'(0),
		REG_IMAGE_HEIGHT = CFG_IDX_W'(1)
	} cfg_reg_t;

	// Per-pixel information handed from the scan stage to the accumulate stage.
	typedef struct packed {
		logic [COL_W-1:0]     col;
		logic                 above_valid;
		logic [ROW_SUM_W-1:0] row_sum;
		logic                 last;
	} scan_info_t;

	// Zero acts as one; anything beyond the maximum acts as the maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] max_v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > max_v) begin
			r = max_v;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

### hdl/integral_image_builder.sv
// Integral image builder: top level with the accumulate stage and output register.
// Depends on iib_pkg, iib_scan, iib_line_mem and integral_image_builder_defines.svh.
//
// Usage:
// Gray pixels enter in raster order on the s_ beat channel, one byte each.
// For every pixel one beat leaves on the m_ channel carrying the sum of all
// pixels at or above its row and at or left of its column; m_tlast marks the
// beat for the final pixel of a frame, after which the next pixel starts a
// new frame. Frame width and height are set through the cfg channel (index
// 0 is the width, index 1 the height); a write restarts the frame and must
// only be made while no pixel is in flight.
// An accepted pixel is registered into stage s1 with its line store read,
// then its sum into the output register that drives m_tdata. One pixel is
// taken every cycle while the receiver does not stall: the line store's
// read and write ports let a read and the prior write-back share a cycle.
// Reset clears the counters and sets width and height to 1024; the line store
// is not cleared because the first row of every frame writes each entry
// before any later row reads it.
// When the receiver stalls with a result waiting, the pipeline holds and
// s_tready falls until the output register frees.
`timescale 1ns / 1ps

`include "integral_image_builder_defines.svh"

module integral_image_builder (
	input  logic                           clk,
	input  logic                           arst_n,
	// Pixel input; s_tdata[7:0] = pixel.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [iib_pkg::S_TDATA_W-1:0]  s_tdata,
	// Result output; m_tdata[27:0] = area_sum, upper bits zero.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [iib_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tlast,
	// Configuration writes.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [iib_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [iib_pkg::DIM_W-1:0]      cfg_data
);

	logic                        s_fire;
	logic                        advance;
	iib_pkg::scan_info_t         info;

	logic                        valid_s1;
	iib_pkg::scan_info_t         info_s1;
	logic                        fwd_s1;
	logic [iib_pkg::AREA_W-1:0]  fwd_data_s1;

	logic [iib_pkg::AREA_W-1:0]  rd_data;
	logic [iib_pkg::AREA_W-1:0]  above;
	logic [iib_pkg::AREA_W-1:0]  total;
	logic                        wr_en;

	logic                        m_valid_q;
	logic [iib_pkg::AREA_W-1:0]  area_q;
	logic                        last_q;

	assign advance   = !m_valid_q || m_tready;
	assign s_tready  = advance;
	assign s_fire    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	iib_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_addr),
		.cfg_value (cfg_data),
		.pix_fire  (s_fire),
		.pixel     (s_tdata[iib_pkg::PIX_W-1:0]),
		.info      (info)
	);

	iib_line_mem u_line_mem (
		.clk     (clk),
		.rd_en   (s_fire),
		.rd_addr (info.col),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (info_s1.col),
		.wr_data (total)
	);

	// Only a one-pixel-wide frame reads the entry being written in the same
	// cycle; that value is carried across in the forwarding register.
	assign above = fwd_s1 ? fwd_data_s1 : rd_data;
	assign total = iib_pkg::AREA_W'(info_s1.row_sum)
		+ (info_s1.above_valid ? above : '0);
	assign wr_en = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_fire;
			fwd_s1   <= s_fire && valid_s1 && (info_s1.col == info.col);
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			info_s1     <= info;
			fwd_data_s1 <= total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			area_q <= total;
			last_q <= info_s1.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = iib_pkg::M_TDATA_W'(area_q);
	assign m_tlast  = last_q;

	`IIB_ASSERT_NEXT(a_fire_fills_s1, s_fire, valid_s1)
	`IIB_ASSERT_NEXT(a_s1_holds_on_stall, valid_s1 && !advance, valid_s1 && $stable(info_s1))
	`IIB_ASSERT_SAME(a_fwd_needs_s1, fwd_s1, valid_s1)
	`IIB_ASSERT_NEXT(a_s1_drains, valid_s1 && advance, m_valid_q && area_q == $past(total))

endmodule

### hdl/iib_line_mem.sv
// Line store of the integral image builder: previous row's integral values.
// Single write port and one registered read port; uses iib_pkg widths.
`timescale 1ns / 1ps

module iib_line_mem (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [iib_pkg::COL_W-1:0]   rd_addr,
	output logic [iib_pkg::AREA_W-1:0]  rd_data,
	input  logic                        wr_en,
	input  logic [iib_pkg::COL_W-1:0]   wr_addr,
	input  logic [iib_pkg::AREA_W-1:0]  wr_data
);

	logic [iib_pkg::AREA_W-1:0] mem [iib_pkg::MAX_WIDTH];
	logic [iib_pkg::AREA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read-before-write on a clash; the caller forwards the fresh value.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/iib_scan.sv
// Raster scan stage: frame geometry registers, column and row counters and
// the running row sum. Depends on iib_pkg.
`timescale 1ns / 1ps

module iib_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [iib_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [iib_pkg::DIM_W-1:0]      cfg_value,
	input  logic                           pix_fire,
	input  logic [iib_pkg::PIX_W-1:0]      pixel,
	output iib_pkg::scan_info_t            info
);

	logic [iib_pkg::DIM_W-1:0]     width_q;
	logic [iib_pkg::DIM_W-1:0]     height_q;
	logic [iib_pkg::COL_W-1:0]     col_q;
	logic [iib_pkg::ROW_W-1:0]     row_q;
	logic [iib_pkg::ROW_SUM_W-1:0] row_sum_q;

	logic [iib_pkg::ROW_SUM_W-1:0] row_sum_next;
	logic                          col_last;
	logic                          row_last;

	assign row_sum_next = row_sum_q + iib_pkg::ROW_SUM_W'(pixel);
	assign col_last = (iib_pkg::DIM_W'(col_q) == (width_q - iib_pkg::DIM_W'(1)));
	assign row_last = (iib_pkg::DIM_W'(row_q) == (height_q - iib_pkg::DIM_W'(1)));

	always_comb begin
		info.col         = col_q;
		info.above_valid = (row_q != '0);
		info.row_sum     = row_sum_next;
		info.last        = col_last && row_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= iib_pkg::DIM_W'(iib_pkg::MAX_WIDTH);
			height_q  <= iib_pkg::DIM_W'(iib_pkg::MAX_HEIGHT);
			col_q     <= '0;
			row_q     <= '0;
			row_sum_q <= '0;
		end else if (cfg_we) begin
			// Any register write restarts the frame.
			unique case (iib_pkg::cfg_reg_t'(cfg_idx))
				iib_pkg::REG_IMAGE_WIDTH: begin
					width_q <= iib_pkg::clamp_dim(cfg_value,
						iib_pkg::DIM_W'(iib_pkg::MAX_WIDTH));
				end
				iib_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= iib_pkg::clamp_dim(cfg_value,
						iib_pkg::DIM_W'(iib_pkg::MAX_HEIGHT));
				end
				default: begin
				end
			endcase
			col_q     <= '0;
			row_q     <= '0;
			row_sum_q <= '0;
		end else if (pix_fire) begin
			if (col_last) begin
				col_q     <= '0;
				row_sum_q <= '0;
				row_q     <= row_last ? '0 : row_q + iib_pkg::ROW_W'(1);
			end else begin
				col_q     <= col_q + iib_pkg::COL_W'(1);
				row_sum_q <= row_sum_next;
			end
		end
	end

endmodule
